/* sv/hne_pkg.sv */
// shared types and constants for the height map normal engine
package hne_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_LENGTH    = 256;
    localparam int OUT_FRAC_BITS = 15;
    localparam int POS_BITS      = 8;
    localparam int HEIGHT_BITS   = 8;
    localparam int NORM_BITS     = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT_SCALE = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [POS_BITS-1:0]    pos_x;
        logic [POS_BITS-1:0]    pos_z;
        logic [HEIGHT_BITS-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [NORM_BITS-1:0] normal_x;
        logic signed [NORM_BITS-1:0] normal_y;
        logic signed [NORM_BITS-1:0] normal_z;
        logic                        in_range;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PT_START,
        ST_READ,
        ST_QUAD,
        ST_MUL_A,
        ST_MUL_B,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_QUAD_NEXT,
        ST_PT_NEXT,
        ST_FINISH
    } state_t;

endpackage

/* sv/heightmap_normal_engine.sv */
// height map store with smoothed vertex normal queries on one shared iterative unit
// an in-map query visits the query point and its four neighbors, with up to four quadrants at
//   each in-map point (at most 20), runs a 32-step square root and three 17-step restoring
//   divisions per in-map quadrant on the shared unit, and then hands over the result word
// throughput: one word at a time; in_stall stays high from a query until its result is queued
// reset: rst_n clears the sequencer and the output valid and resets the configuration registers;
//   the height memory is not cleared and an entry is undefined until written
module heightmap_normal_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  hne_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output hne_pkg::out_word_t                  out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hne_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hne_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import hne_pkg::*;

    localparam int OUT_SHIFT = 17 - OUT_FRAC_BITS;
    localparam logic [23:0] ROUND_HALF = 24'(1 << (OUT_SHIFT - 1));
    localparam logic [23:0] SAT_MAG = 24'((1 << (NORM_BITS - 1)) - 1);
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_LENGTH;

    // neighbor directions inside one point's read burst
    localparam logic [2:0] DIR_C = 3'd0;
    localparam logic [2:0] DIR_L = 3'd1;
    localparam logic [2:0] DIR_R = 3'd2;
    localparam logic [2:0] DIR_U = 3'd3;
    localparam logic [2:0] DIR_D = 3'd4;
    localparam logic [2:0] DIR_LAST = 3'd5;

    // x/z offset of each direction; points use the same table around the query
    function automatic logic signed [9:0] off_x(input logic [2:0] d);
        case (d)
            DIR_L:   off_x = -10'sd1;
            DIR_R:   off_x = 10'sd1;
            default: off_x = 10'sd0;
        endcase
    endfunction

    function automatic logic signed [9:0] off_z(input logic [2:0] d);
        case (d)
            DIR_U:   off_z = -10'sd1;
            DIR_D:   off_z = 10'sd1;
            default: off_z = 10'sd0;
        endcase
    endfunction

    // q17 sum to output field, round half away from zero, saturate
    function automatic logic signed [NORM_BITS-1:0] to_field(input logic signed [23:0] t);
        logic        neg;
        logic [23:0] m;
        logic [23:0] r;
        neg = t[23];
        m   = neg ? (~t + 24'd1) : t;
        r   = (m + ROUND_HALF) >> OUT_SHIFT;
        if (r > SAT_MAG)
        begin
            r = SAT_MAG;
        end
        to_field = neg ? -NORM_BITS'(r) : NORM_BITS'(r);
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [8:0]  map_width_reg, map_length_reg;
    logic [23:0] height_scale_reg;
    logic [8:0]  w_eff, l_eff;

    // query context
    logic [POS_BITS-1:0] qx_reg, qz_reg;
    logic                in_range_reg;
    logic [2:0]          pt_reg;
    logic [1:0]          quad_reg;
    logic [2:0]          rd_cnt_reg;

    // heights of the current point and its four neighbors
    logic [HEIGHT_BITS-1:0] hc_reg, hl_reg, hr_reg, hu_reg, hd_reg;

    // shared unit datapath
    logic [31:0] ma_reg, mb_reg;
    logic        nega_reg, negb_reg;
    logic [30:0] pa_reg, pb_reg, p1_reg;
    logic [1:0]  sq_cnt_reg;
    logic [63:0] sum_reg;
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [4:0]  sqrt_cnt_reg;
    logic [1:0]  comp_reg;
    logic [31:0] rem_reg;
    logic [16:0] numlo_reg, quo_reg;
    logic [4:0]  div_cnt_reg;

    // accumulators: rough normal in q16, smoothed sum in q17
    logic signed [19:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [23:0] t_x_reg, t_y_reg, t_z_reg;

    out_word_t out_word_reg;
    logic      out_valid_reg;

    // height memory
    logic [HEIGHT_BITS-1:0] mem [MEM_DEPTH];
    logic [HEIGHT_BITS-1:0] rd_data_reg;
    logic [15:0]            rd_addr;
    logic                   wr_en;

    logic in_acc, out_free;

    // point geometry
    logic signed [9:0] px, pz, ax, az;
    logic pt_ok, has_l, has_r, has_u, has_d, quad_en;

    // quadrant operands
    logic [HEIGHT_BITS-1:0] h_a, h_b;
    logic signed [8:0]      diff_a, diff_b;
    logic [7:0]             mag_a, mag_b;
    logic                   flip_a, flip_b;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [30:0] p_sel;
    logic [63:0] root_try;
    logic        root_ge;
    logic [47:0] num;
    logic [32:0] div_try;
    logic        div_ge;
    logic signed [19:0] q_signed;
    logic        m_shift;

    assign w_eff = (map_width_reg == 9'd0) ? 9'd1 :
                   (map_width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : map_width_reg;
    assign l_eff = (map_length_reg == 9'd0) ? 9'd1 :
                   (map_length_reg > 9'(MAX_LENGTH)) ? 9'(MAX_LENGTH) : map_length_reg;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_en    = in_acc && (in_word.func == FUNC_WRITE)
                   && ({1'b0, in_word.pos_x} < w_eff) && ({1'b0, in_word.pos_z} < l_eff);

    // current point and its neighbor flags
    always_comb
    begin
        px = $signed({2'b00, qx_reg}) + off_x(pt_reg);
        pz = $signed({2'b00, qz_reg}) + off_z(pt_reg);
        pt_ok = (px >= 10'sd0) && (pz >= 10'sd0)
             && (px < $signed({1'b0, w_eff})) && (pz < $signed({1'b0, l_eff}));
        has_l = px > 10'sd0;
        has_r = (px + 10'sd1) < $signed({1'b0, w_eff});
        has_u = pz > 10'sd0;
        has_d = (pz + 10'sd1) < $signed({1'b0, l_eff});
        ax = px + off_x(rd_cnt_reg);
        az = pz + off_z(rd_cnt_reg);
        rd_addr = {az[7:0], ax[7:0]};
    end

    // quadrant vector (a, 1, b): a from left or negated right, b from up or negated down
    always_comb
    begin
        case (quad_reg)
            2'd0:    quad_en = has_l && has_u;
            2'd1:    quad_en = has_l && has_d;
            2'd2:    quad_en = has_r && has_d;
            default: quad_en = has_r && has_u;
        endcase
        h_a    = quad_reg[1] ? hr_reg : hl_reg;
        flip_a = quad_reg[1];
        h_b    = (quad_reg == 2'd0 || quad_reg == 2'd3) ? hu_reg : hd_reg;
        flip_b = (quad_reg == 2'd1 || quad_reg == 2'd2);
        diff_a = $signed({1'b0, h_a}) - $signed({1'b0, hc_reg});
        diff_b = $signed({1'b0, h_b}) - $signed({1'b0, hc_reg});
        mag_a  = diff_a[8] ? 8'(-diff_a) : diff_a[7:0];
        mag_b  = diff_b[8] ? 8'(-diff_b) : diff_b[7:0];
    end

    // the shared multiplier: height differences, then the three squares
    always_comb
    begin
        case (comp_reg)
            2'd0:    p_sel = pa_reg;
            2'd1:    p_sel = p1_reg;
            default: p_sel = pb_reg;
        endcase
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = {8'd0, height_scale_reg};
                mul_b = {24'd0, mag_a};
            end
            ST_MUL_B:
            begin
                mul_a = {8'd0, height_scale_reg};
                mul_b = {24'd0, mag_b};
            end
            ST_SQ:
            begin
                case (sq_cnt_reg)
                    2'd0:    mul_a = {1'b0, pa_reg};
                    2'd1:    mul_a = {1'b0, pb_reg};
                    default: mul_a = {1'b0, p1_reg};
                endcase
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // one root step and one division step per cycle
    always_comb
    begin
        m_shift  = ma_reg[31] || mb_reg[31];
        root_try = r_reg + bit_reg;
        root_ge  = v_reg >= root_try;
        num      = {1'b0, p_sel, 16'd0} + {17'd0, r_reg[31:1]};
        div_try  = {rem_reg, numlo_reg[16]};
        div_ge   = div_try >= {1'b0, r_reg[31:0]};
        if ((comp_reg == 2'd0 && nega_reg) || (comp_reg == 2'd2 && negb_reg))
        begin
            q_signed = -$signed({3'b000, quo_reg});
        end
        else
        begin
            q_signed = $signed({3'b000, quo_reg});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_word.func == FUNC_QUERY)
                begin
                    if (({1'b0, in_word.pos_x} < w_eff) && ({1'b0, in_word.pos_z} < l_eff))
                    begin
                        state_next = ST_PT_START;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PT_START:  state_next = pt_ok ? ST_READ : ST_PT_NEXT;
            ST_READ:      state_next = (rd_cnt_reg == DIR_LAST) ? ST_QUAD : ST_READ;
            ST_QUAD:      state_next = quad_en ? ST_MUL_A : ST_QUAD_NEXT;
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_SHIFT;
            ST_SHIFT:     state_next = ST_SQ;
            ST_SQ:        state_next = (sq_cnt_reg == 2'd2) ? ST_SQRT : ST_SQ;
            ST_SQRT:      state_next = (sqrt_cnt_reg == 5'd31) ? ST_DIV_INIT : ST_SQRT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV:       state_next = (div_cnt_reg == 5'd16) ? ST_DIV_DONE : ST_DIV;
            ST_DIV_DONE:  state_next = (comp_reg == 2'd2) ? ST_QUAD_NEXT : ST_DIV_INIT;
            ST_QUAD_NEXT: state_next = (quad_reg == 2'd3) ? ST_PT_NEXT : ST_QUAD;
            ST_PT_NEXT:   state_next = (pt_reg == 3'd4) ? ST_FINISH : ST_PT_START;
            ST_FINISH:    state_next = out_free ? ST_IDLE : ST_FINISH;
            default:      state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;
        out_valid = out_valid_reg;
        out_word  = out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            map_width_reg    <= 9'(MAX_WIDTH);
            map_length_reg   <= 9'(MAX_LENGTH);
            height_scale_reg <= 24'd65536;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:    map_width_reg    <= cfg_data[8:0];
                    REG_MAP_LENGTH:   map_length_reg   <= cfg_data[8:0];
                    REG_HEIGHT_SCALE: height_scale_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // height memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{in_word.pos_z, in_word.pos_x}] <= in_word.sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg       <= in_word.pos_x;
                qz_reg       <= in_word.pos_z;
                in_range_reg <= ({1'b0, in_word.pos_x} < w_eff)
                             && ({1'b0, in_word.pos_z} < l_eff);
                pt_reg       <= 3'd0;
                t_x_reg      <= 24'sd0;
                t_y_reg      <= 24'sd0;
                t_z_reg      <= 24'sd0;
            end
            ST_PT_START:
            begin
                rd_cnt_reg <= DIR_C;
                quad_reg   <= 2'd0;
                acc_x_reg  <= 20'sd0;
                acc_y_reg  <= 20'sd0;
                acc_z_reg  <= 20'sd0;
            end
            ST_READ:
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
                // data lands in the cycle after its address
                case (rd_cnt_reg)
                    3'd1:    hc_reg <= rd_data_reg;
                    3'd2:    hl_reg <= rd_data_reg;
                    3'd3:    hr_reg <= rd_data_reg;
                    3'd4:    hu_reg <= rd_data_reg;
                    3'd5:    hd_reg <= rd_data_reg;
                    default: ;
                endcase
            end
            ST_MUL_A:
            begin
                ma_reg   <= prod[31:0];
                nega_reg <= diff_a[8] ^ flip_a;
            end
            ST_MUL_B:
            begin
                mb_reg   <= prod[31:0];
                negb_reg <= diff_b[8] ^ flip_b;
            end
            ST_SHIFT:
            begin
                // magnitudes stay below 2^32, so one shift at most
                pa_reg     <= m_shift ? ma_reg[31:1] : ma_reg[30:0];
                pb_reg     <= m_shift ? mb_reg[31:1] : mb_reg[30:0];
                p1_reg     <= m_shift ? 31'd32768 : 31'd65536;
                sum_reg    <= 64'd0;
                sq_cnt_reg <= 2'd0;
            end
            ST_SQ:
            begin
                sum_reg      <= sum_reg + prod;
                sq_cnt_reg   <= sq_cnt_reg + 2'd1;
                v_reg        <= sum_reg + prod;
                r_reg        <= 64'd0;
                bit_reg      <= 64'd1 << 62;
                sqrt_cnt_reg <= 5'd0;
                comp_reg     <= 2'd0;
            end
            ST_SQRT:
            begin
                if (root_ge)
                begin
                    v_reg <= v_reg - root_try;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg      <= bit_reg >> 2;
                sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
            end
            ST_DIV_INIT:
            begin
                // quotient fits 17 bits, so the upper part is already below the divisor
                rem_reg     <= {1'b0, num[47:17]};
                numlo_reg   <= num[16:0];
                quo_reg     <= 17'd0;
                div_cnt_reg <= 5'd0;
            end
            ST_DIV:
            begin
                rem_reg     <= div_ge ? 32'(div_try - {1'b0, r_reg[31:0]}) : div_try[31:0];
                quo_reg     <= {quo_reg[15:0], div_ge};
                numlo_reg   <= {numlo_reg[15:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            ST_DIV_DONE:
            begin
                case (comp_reg)
                    2'd0:    acc_x_reg <= acc_x_reg + q_signed;
                    2'd1:    acc_y_reg <= acc_y_reg + q_signed;
                    default: acc_z_reg <= acc_z_reg + q_signed;
                endcase
                comp_reg <= comp_reg + 2'd1;
            end
            ST_QUAD_NEXT:
            begin
                quad_reg <= quad_reg + 2'd1;
            end
            ST_PT_NEXT:
            begin
                if (pt_ok)
                begin
                    // centre counts twice in the q17 sum, neighbors once
                    if (pt_reg == 3'd0)
                    begin
                        t_x_reg <= t_x_reg + (24'(acc_x_reg) <<< 1);
                        t_y_reg <= t_y_reg + (24'(acc_y_reg) <<< 1);
                        t_z_reg <= t_z_reg + (24'(acc_z_reg) <<< 1);
                    end
                    else
                    begin
                        t_x_reg <= t_x_reg + 24'(acc_x_reg);
                        t_y_reg <= t_y_reg + 24'(acc_y_reg);
                        t_z_reg <= t_z_reg + 24'(acc_z_reg);
                    end
                end
                pt_reg <= pt_reg + 3'd1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_word_reg.in_range <= in_range_reg;
                    if (!in_range_reg)
                    begin
                        out_word_reg.normal_x <= '0;
                        out_word_reg.normal_y <= '0;
                        out_word_reg.normal_z <= '0;
                    end
                    else if (t_x_reg == 24'sd0 && t_y_reg == 24'sd0 && t_z_reg == 24'sd0)
                    begin
                        // degenerate normal points straight up
                        out_word_reg.normal_x <= '0;
                        out_word_reg.normal_y <= to_field(24'sd131072);
                        out_word_reg.normal_z <= '0;
                    end
                    else
                    begin
                        out_word_reg.normal_x <= to_field(t_x_reg);
                        out_word_reg.normal_y <= to_field(t_y_reg);
                        out_word_reg.normal_z <= to_field(t_z_reg);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

/* sv/hne_checker.sv */
// port-level checks for the height map normal engine, bound to the top level
module hne_port_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  hne_pkg::in_word_t                   in_word,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  hne_pkg::out_word_t                  out_word,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);
    import hne_pkg::*;

    // a query keeps the block busy on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.func == FUNC_QUERY |=> in_stall)
        else $error("query accepted but input not stalled");

    // out-of-map result carries a zero normal
    a_out_of_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.in_range |->
        out_word.normal_x == '0 && out_word.normal_y == '0 && out_word.normal_z == '0)
        else $error("out-of-map result with nonzero normal");

    // in-map result never has a zero normal
    a_in_map_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.in_range |->
        !(out_word.normal_x == '0 && out_word.normal_y == '0 && out_word.normal_z == '0))
        else $error("in-map result with zero normal");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result changed");

    // register writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write not accepted");

endmodule

bind heightmap_normal_engine hne_port_checker u_hne_checker (.*);

/* tb/sv/hne_checker.sv */
// predictor and result comparison for the height map normal engine testbench
module hne_checker
    import hne_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  in_word_t                 in_word,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  out_word_t                out_word,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fails,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE_Q16 = 64'd65536;
    localparam longint unsigned SAT_MAG = 64'd524287;

    logic [HEIGHT_BITS-1:0] height_mem [MAX_WIDTH*MAX_LENGTH];
    logic [8:0]             width_reg;
    logic [8:0]             length_reg;
    logic [23:0]            scale_reg;
    out_word_t              normal_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint scaled_part(longint unsigned p, bit neg, longint unsigned len);
        longint unsigned q;
        q = (p * ONE_Q16 + len / 2) / len;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // adds the unit vector of (a, 1, b) to the running sum, all 16 fractional bits
    function automatic void add_unit_vec(longint a, longint b,
                                         inout longint sx, inout longint sy, inout longint sz);
        longint unsigned ma, mb, m, pa, pb, p1, len;
        int s;
        ma = abs64(a);
        mb = abs64(b);
        m  = ONE_Q16;
        s  = 0;
        if (ma > m) m = ma;
        if (mb > m) m = mb;
        while ((m >> s) >= (64'd1 << 31)) s++;
        pa  = ma >> s;
        pb  = mb >> s;
        p1  = ONE_Q16 >> s;
        len = int_sqrt(pa * pa + pb * pb + p1 * p1);
        if (len == 0) len = 1;
        sx += scaled_part(pa, a < 0, len);
        sy += scaled_part(p1, 1'b0, len);
        sz += scaled_part(pb, b < 0, len);
    endfunction

    function automatic int height_at(int x, int z);
        return int'(height_mem[(z * MAX_WIDTH + x) % (MAX_WIDTH * MAX_LENGTH)]);
    endfunction

    function automatic longint rise(int x, int z, int c);
        return longint'(scale_reg) * longint'(height_at(x, z) - c);
    endfunction

    function automatic void rough_at(int x, int z, int w, int l,
                                     output longint sx, output longint sy, output longint sz);
        int c;
        bit hl, hr, hu, hd;
        longint dl, dr, du, dd;
        c  = height_at(x, z);
        hl = x > 0;
        hr = x + 1 < w;
        hu = z > 0;
        hd = z + 1 < l;
        dl = hl ? rise(x - 1, z, c) : 0;
        dr = hr ? rise(x + 1, z, c) : 0;
        du = hu ? rise(x, z - 1, c) : 0;
        dd = hd ? rise(x, z + 1, c) : 0;
        sx = 0;
        sy = 0;
        sz = 0;
        if (hl && hu) add_unit_vec(dl, du, sx, sy, sz);
        if (hl && hd) add_unit_vec(dl, -dd, sx, sy, sz);
        if (hr && hd) add_unit_vec(-dr, -dd, sx, sy, sz);
        if (hr && hu) add_unit_vec(-dr, du, sx, sy, sz);
    endfunction

    // 17 fractional bits down to the output format, half away from zero, saturated
    function automatic logic signed [NORM_BITS-1:0] to_out(longint t);
        longint unsigned m;
        longint v;
        m = abs64(t);
        m = (m + 2) >> 2;
        if (m > SAT_MAG) m = SAT_MAG;
        v = (t < 0) ? -longint'(m) : longint'(m);
        return v[NORM_BITS-1:0];
    endfunction

    function automatic out_word_t smoothed_normal(int x, int z, int w, int l);
        out_word_t r;
        longint tx, ty, tz, nx, ny, nz;
        r = '0;
        if (x >= w || z >= l) return r;
        rough_at(x, z, w, l, tx, ty, tz);
        tx = 2 * tx;
        ty = 2 * ty;
        tz = 2 * tz;
        if (x > 0)
        begin
            rough_at(x - 1, z, w, l, nx, ny, nz);
            tx += nx; ty += ny; tz += nz;
        end
        if (x + 1 < w)
        begin
            rough_at(x + 1, z, w, l, nx, ny, nz);
            tx += nx; ty += ny; tz += nz;
        end
        if (z > 0)
        begin
            rough_at(x, z - 1, w, l, nx, ny, nz);
            tx += nx; ty += ny; tz += nz;
        end
        if (z + 1 < l)
        begin
            rough_at(x, z + 1, w, l, nx, ny, nz);
            tx += nx; ty += ny; tz += nz;
        end
        if (tx == 0 && ty == 0 && tz == 0) ty = longint'(1) << 17;
        r.normal_x = to_out(tx);
        r.normal_y = to_out(ty);
        r.normal_z = to_out(tz);
        r.in_range = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        int w, l;
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            length_reg <= 9'd256;
            scale_reg  <= 24'd65536;
            fails      <= 0;
            pending    <= 0;
            normal_q.delete();
            for (int i = 0; i < MAX_WIDTH * MAX_LENGTH; i++) height_mem[i] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:    width_reg  <= cfg_data[8:0];
                    REG_MAP_LENGTH:   length_reg <= cfg_data[8:0];
                    REG_HEIGHT_SCALE: scale_reg  <= cfg_data;
                    default: ;
                endcase
            end
            w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            l = (length_reg < 1) ? 1 : (length_reg > MAX_LENGTH) ? MAX_LENGTH : int'(length_reg);
            if (in_valid && !in_stall)
            begin
                if (in_word.func == FUNC_WRITE)
                begin
                    if (in_word.pos_x < w && in_word.pos_z < l)
                        height_mem[int'(in_word.pos_z) * MAX_WIDTH + int'(in_word.pos_x)] =
                            in_word.sample;
                end
                else
                    normal_q.push_back(smoothed_normal(in_word.pos_x, in_word.pos_z, w, l));
            end
            if (out_valid && !out_stall)
            begin
                if (normal_q.size() == 0)
                begin
                    $error("unexpected result word %h", out_word);
                    fails <= fails + 1;
                end
                else
                begin
                    e = normal_q.pop_front();
                    if (out_word.normal_x !== e.normal_x)
                        $error("normal_x expected %0d got %0d", e.normal_x, out_word.normal_x);
                    if (out_word.normal_y !== e.normal_y)
                        $error("normal_y expected %0d got %0d", e.normal_y, out_word.normal_y);
                    if (out_word.normal_z !== e.normal_z)
                        $error("normal_z expected %0d got %0d", e.normal_z, out_word.normal_z);
                    if (out_word.in_range !== e.in_range)
                        $error("in_range expected %0d got %0d", e.in_range, out_word.in_range);
                    if (out_word !== e) fails <= fails + 1;
                end
            end
            pending <= normal_q.size();
        end
    end

endmodule

/* tb/sv/heightmap_normal_engine_tb.sv */
// stimulus, reset, back pressure and verdict for the height map normal engine
module heightmap_normal_engine_tb;
    import hne_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;   // cycles without any handshake
    localparam int ITEM_GOAL  = 1500;
    localparam int LONG_HOLD  = 400;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    in_word_t                 in_word;
    logic                     out_valid;
    logic                     out_stall;
    out_word_t                out_word;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       fails;
    int                       pending;

    // which height entries have been written, so no query touches an unwritten one
    bit                       seen [MAX_WIDTH*MAX_LENGTH];
    int                       cur_w;
    int                       cur_l;
    int                       sent;
    int                       idle_count = 0;
    bit                       calm;        // no random gaps on either side
    bit                       hold_req;    // ask the receiver for one long hold-off

    heightmap_normal_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hne_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: any cycle with a handshake on some channel restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("heightmap_normal_engine_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall per word, one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                n = calm ? 0 : $urandom_range(0, 4);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            // wait for the word to go through with stall low
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // one input word; valid stays high across back-to-back words
    task automatic send_word(logic fn, int x, int z, int s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_word.func   <= fn;
        in_word.pos_x  <= x[POS_BITS-1:0];
        in_word.pos_z  <= z[POS_BITS-1:0];
        in_word.sample <= s[HEIGHT_BITS-1:0];
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic put_height(int x, int z, int s);
        send_word(FUNC_WRITE, x, z, s);
        if (x < cur_w && z < cur_l) seen[z * MAX_WIDTH + x] = 1'b1;
    endtask

    // fill the 13-point neighborhood where needed, then ask for the normal
    task automatic query_at(int x, int z);
        int px, pz;
        for (int dz = -2; dz <= 2; dz++)
            for (int dx = -2; dx <= 2; dx++)
            begin
                px = x + dx;
                pz = z + dz;
                if ((dx < 0 ? -dx : dx) + (dz < 0 ? -dz : dz) <= 2 &&
                    px >= 0 && pz >= 0 && px < cur_w && pz < cur_l)
                    if (!seen[pz * MAX_WIDTH + px] || $urandom_range(0, 3) == 0)
                        put_height(px, pz, $urandom_range(0, 255));
            end
        send_word(FUNC_QUERY, x, z, $urandom_range(0, 255));
    endtask

    // settle: every result back, then a short pause for a trailing write
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_BITS-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_BITS-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // all three registers; clamping of the map size mirrored for the stimulus
    task automatic set_map(int w, int l, int scale);
        drain();
        reg_write(REG_MAP_WIDTH, w);
        reg_write(REG_MAP_LENGTH, l);
        reg_write(REG_HEIGHT_SCALE, scale);
        w = w & 9'h1ff;
        l = l & 9'h1ff;
        cur_w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_l = (l < 1) ? 1 : (l > MAX_LENGTH) ? MAX_LENGTH : l;
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return MAX_WIDTH;
            1:       return $urandom_range(0, 511);
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    function automatic int pick_scale();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 24'hffffff;
            2:       return 65536;
            3:       return $urandom_range(0, 24'hffffff);
            default: return $urandom_range(0, 24'h3ffff);
        endcase
    endfunction

    initial
    begin
        int phase, r, x, z;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;
        cur_w      = MAX_WIDTH;
        cur_l      = MAX_LENGTH;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners and middle of the full map, extreme samples
        put_height(0, 0, 255);
        query_at(0, 0);
        query_at(255, 255);
        query_at(128, 77);
        put_height(128, 77, 0);
        query_at(128, 78);

        // small map, largest scale: out-of-map words and a checkerboard of extremes
        set_map(5, 3, 24'hffffff);
        for (int i = 0; i < 15; i++) put_height(i % 5, i / 5, ((i % 2) != 0) ? 255 : 0);
        send_word(FUNC_QUERY, 2, 1, 0);
        send_word(FUNC_QUERY, 4, 2, 0);
        send_word(FUNC_QUERY, 255, 255, 255);
        send_word(FUNC_WRITE, 255, 0, 170);
        send_word(FUNC_WRITE, 0, 255, 85);

        // a single-column map has no quadrant, so the normal is straight up
        set_map(0, 300, 0);
        reg_write(REG_UNUSED, 24'h5a5a5a);
        query_at(0, 0);
        send_word(FUNC_QUERY, 1, 0, 0);

        // flat column with zero scale
        set_map(1, 256, 0);
        query_at(0, 200);

        // random phases
        phase = 0;
        while (sent < ITEM_GOAL)
        begin
            set_map(pick_size(), pick_size(), pick_scale());
            calm = (phase % 5 == 3);
            if (phase == 2) hold_req = 1'b1;
            for (int k = 0; k < 40 && sent < ITEM_GOAL; k++)
            begin
                r = $urandom_range(0, 19);
                x = $urandom_range(0, cur_w - 1);
                z = $urandom_range(0, cur_l - 1);
                if (r < 13)
                    query_at(x, z);
                else if (r < 16)
                    put_height(x, z, $urandom_range(0, 255));
                else if (r < 18 && cur_w < MAX_WIDTH)
                    send_word(r[0] ? FUNC_QUERY : FUNC_WRITE,
                              $urandom_range(cur_w, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
                else if (cur_l < MAX_LENGTH)
                    send_word(r[0] ? FUNC_QUERY : FUNC_WRITE,
                              $urandom_range(0, 255), $urandom_range(cur_l, 255),
                              $urandom_range(0, 255));
                else
                    put_height(x, z, $urandom_range(0, 255));
                // now and then the sender waits for the block to empty
                if ($urandom_range(0, 29) == 0) drain();
            end
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("heightmap_normal_engine_tb: done, clean");
        else
            $display("heightmap_normal_engine_tb: done, errors");
        $finish;
    end

endmodule

/* heightmap_normal_engine.f */
sv/hne_pkg.sv
sv/heightmap_normal_engine.sv
sv/hne_checker.sv
tb/sv/hne_checker.sv
tb/sv/heightmap_normal_engine_tb.sv
